### design/cdtssm_pkg.sv
// types, constants and segment encoding shared by the countdown timer display block
`timescale 1ns / 1ps

package cdtssm_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int SECP_W     = 24;
    localparam int REFP_W     = 16;
    localparam int COLON_W    = 2;
    localparam int COUNT_W    = 14;
    localparam int START_W    = 16;
    localparam int SEG_W      = 8;
    localparam int MIN_W      = 8;
    localparam int SECS_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 14'd9999;
    localparam logic [SEG_W-1:0]   DOT_BIT   = 8'h80;

    localparam logic [SECP_W-1:0]  SECOND_PERIOD_RST  = 24'd1000000;
    localparam logic [REFP_W-1:0]  REFRESH_PERIOD_RST = 16'd4000;
    localparam logic [COLON_W-1:0] COLON_POSITION_RST = 2'd1;

    // item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // divide by 60 as multiply by reciprocal, exact for counts below 2^14
    localparam int                MIN_RECIP_W = 15;
    localparam logic [14:0]       MIN_RECIP   = 15'd17477;
    localparam int                MIN_SHIFT   = 20;
    localparam logic [MIN_W-1:0]  SECS_PER_MIN = 8'd60;

    // divide by 10 as multiply by reciprocal, exact for values below 256
    localparam logic [7:0]        TEN_RECIP = 8'd205;
    localparam int                TEN_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECOND_PERIOD  = 2'd0,
        REG_REFRESH_PERIOD = 2'd1,
        REG_COLON_POSITION = 2'd2
    } cfg_reg_t;

    function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

### design/cdtssm_ifs.sv
// valid/ready channel interfaces for command, display and configuration items
`timescale 1ns / 1ps

interface cdtssm_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [cdtssm_pkg::START_W-1:0] start_seconds;

    modport source (output valid, func, start_seconds, input ready);
    modport sink   (input valid, func, start_seconds, output ready);
endinterface

interface cdtssm_disp_if;
    logic                           valid;
    logic                           ready;
    logic [cdtssm_pkg::POS_W-1:0]   digit_select;
    logic [cdtssm_pkg::SEG_W-1:0]   segment_byte;
    logic [cdtssm_pkg::COUNT_W-1:0] seconds_left;
    logic                           counting;

    modport source (output valid, digit_select, segment_byte, seconds_left, counting,
                    input ready);
    modport sink   (input valid, digit_select, segment_byte, seconds_left, counting,
                    output ready);
endinterface

interface cdtssm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cdtssm_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [cdtssm_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/countdown_timer_seven_segment_mux_unit.sv
// countdown timer with multiplexed seven-segment display output, top level
// a display item follows the tick through the refresh, minutes and output stages
// throughput: one item per cycle unless disp.ready stalls; state is updated in the stage
// after the input register, and the mm:ss digit split runs over two more stages behind it
// reset: count, run flag, phases, digit position and all valids clear; registers take
// second_period 1000000, refresh_period 4000, colon_position 1
`timescale 1ns / 1ps

module countdown_timer_seven_segment_mux_unit (
    input  logic                clk,
    input  logic                rst_n,
    cdtssm_cfg_if.sink          cfg,
    cdtssm_cmd_if.sink          cmd,
    cdtssm_disp_if.source       disp
);

    // configuration
    logic [cdtssm_pkg::SECP_W-1:0]  second_period_reg;
    logic [cdtssm_pkg::REFP_W-1:0]  refresh_period_reg;
    logic [cdtssm_pkg::COLON_W-1:0] colon_position_reg;

    // timer state
    logic [cdtssm_pkg::COUNT_W-1:0] remaining_reg, remaining_next;
    logic                           running_reg, running_next;
    logic [cdtssm_pkg::SECP_W-1:0]  second_phase_reg, second_phase_next;
    logic [cdtssm_pkg::REFP_W-1:0]  refresh_phase_reg, refresh_phase_next;
    logic [cdtssm_pkg::POS_W-1:0]   position_reg, position_next;

    // input stage
    logic                           p_valid_reg;
    logic                           p_func_reg;
    logic [cdtssm_pkg::START_W-1:0] p_start_reg;

    // refresh stage
    logic                           q_valid_reg, q_valid_next;
    logic [cdtssm_pkg::POS_W-1:0]   q_pos_reg;
    logic [cdtssm_pkg::COUNT_W-1:0] q_remaining_reg;
    logic                           q_running_reg;
    logic                           q_dot_reg;

    // minutes stage
    logic                           r_valid_reg;
    logic [cdtssm_pkg::POS_W-1:0]   r_pos_reg;
    logic [cdtssm_pkg::COUNT_W-1:0] r_remaining_reg;
    logic                           r_running_reg;
    logic                           r_dot_reg;
    logic [cdtssm_pkg::MIN_W-1:0]   r_minutes_reg, r_minutes_next;

    // output stage
    logic                           o_valid_reg;
    logic [cdtssm_pkg::POS_W-1:0]   o_pos_reg;
    logic [cdtssm_pkg::SEG_W-1:0]   o_seg_reg, o_seg_next;
    logic [cdtssm_pkg::COUNT_W-1:0] o_remaining_reg;
    logic                           o_running_reg;

    logic o_ready, r_ready, q_ready, p_fire, cmd_fire;

    logic [cdtssm_pkg::SECP_W-1:0]  sec_inc;
    logic                           sec_wrap;
    logic [cdtssm_pkg::REFP_W-1:0]  ref_inc;
    logic                           ref_wrap;

    logic [cdtssm_pkg::COUNT_W+cdtssm_pkg::MIN_RECIP_W-1:0] min_prod;
    logic [cdtssm_pkg::COUNT_W-1:0] min_times60;
    logic [cdtssm_pkg::COUNT_W-1:0] secs_full;
    logic [cdtssm_pkg::MIN_W-1:0]   split_val;
    logic [15:0]                    ten_prod;
    logic [4:0]                     quot;
    logic [cdtssm_pkg::MIN_W-1:0]   quot_times10;
    logic [cdtssm_pkg::MIN_W-1:0]   rem_full;
    logic [cdtssm_pkg::DIGIT_W-1:0] tens_digit;
    logic [cdtssm_pkg::DIGIT_W-1:0] digit;

    // handshake chain
    assign o_ready   = !o_valid_reg || disp.ready;
    assign r_ready   = !r_valid_reg || o_ready;
    assign q_ready   = !q_valid_reg || r_ready;
    assign p_fire    = p_valid_reg && q_ready;
    assign cmd.ready = !p_valid_reg || q_ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_period_reg  <= cdtssm_pkg::SECOND_PERIOD_RST;
            refresh_period_reg <= cdtssm_pkg::REFRESH_PERIOD_RST;
            colon_position_reg <= cdtssm_pkg::COLON_POSITION_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                cdtssm_pkg::REG_SECOND_PERIOD:
                    second_period_reg <= cfg.wdata[cdtssm_pkg::SECP_W-1:0];
                cdtssm_pkg::REG_REFRESH_PERIOD:
                    refresh_period_reg <= cfg.wdata[cdtssm_pkg::REFP_W-1:0];
                cdtssm_pkg::REG_COLON_POSITION:
                    colon_position_reg <= cfg.wdata[cdtssm_pkg::COLON_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // timer and refresh state update
    always_comb
    begin
        remaining_next     = remaining_reg;
        running_next       = running_reg;
        second_phase_next  = second_phase_reg;
        refresh_phase_next = refresh_phase_reg;
        position_next      = position_reg;
        q_valid_next       = 1'b0;
        sec_inc            = second_phase_reg + 1'b1;
        sec_wrap           = (sec_inc == '0) || (sec_inc >= second_period_reg);
        ref_inc            = refresh_phase_reg + 1'b1;
        ref_wrap           = (ref_inc == '0) || (ref_inc >= refresh_period_reg);

        if (p_fire)
        begin
            if (p_func_reg == cdtssm_pkg::FUNC_START)
            begin
                if (p_start_reg > {2'b00, cdtssm_pkg::MAX_COUNT})
                    remaining_next = cdtssm_pkg::MAX_COUNT;
                else
                    remaining_next = p_start_reg[cdtssm_pkg::COUNT_W-1:0];
                running_next = 1'b1;
            end
            else
            begin
                if (running_reg)
                begin
                    if (sec_wrap)
                    begin
                        second_phase_next = '0;
                        if (remaining_reg != '0)
                            remaining_next = remaining_reg - 1'b1;
                        else
                            running_next = 1'b0;
                    end
                    else
                    begin
                        second_phase_next = sec_inc;
                    end
                end
                else
                begin
                    second_phase_next = '0;
                end

                if (ref_wrap)
                begin
                    refresh_phase_next = '0;
                    position_next      = position_reg + 1'b1;
                    q_valid_next       = 1'b1;
                end
                else
                begin
                    refresh_phase_next = ref_inc;
                end
            end
        end
    end

    // mm:ss split and segment lookup
    always_comb
    begin
        min_prod       = q_remaining_reg * cdtssm_pkg::MIN_RECIP;
        r_minutes_next = min_prod[cdtssm_pkg::MIN_SHIFT +: cdtssm_pkg::MIN_W];

        min_times60 = {6'd0, r_minutes_reg} * {6'd0, cdtssm_pkg::SECS_PER_MIN};
        secs_full   = r_remaining_reg - min_times60;
        if (r_pos_reg[1])
            split_val = {2'b00, secs_full[cdtssm_pkg::SECS_W-1:0]};
        else
            split_val = r_minutes_reg;

        ten_prod     = split_val * cdtssm_pkg::TEN_RECIP;
        quot         = ten_prod[cdtssm_pkg::TEN_SHIFT +: 5];
        quot_times10 = {3'b000, quot} * 8'd10;
        rem_full     = split_val - quot_times10;
        if (quot >= 5'd10)
            tens_digit = 4'(quot - 5'd10);
        else
            tens_digit = quot[cdtssm_pkg::DIGIT_W-1:0];

        if (r_pos_reg[0])
            digit = rem_full[cdtssm_pkg::DIGIT_W-1:0];
        else
            digit = tens_digit;

        o_seg_next = cdtssm_pkg::seg_encode(digit);
        if (r_dot_reg)
            o_seg_next = o_seg_next | cdtssm_pkg::DOT_BIT;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg     <= '0;
            running_reg       <= 1'b0;
            second_phase_reg  <= '0;
            refresh_phase_reg <= '0;
            position_reg      <= '0;
            p_valid_reg       <= 1'b0;
            q_valid_reg       <= 1'b0;
            r_valid_reg       <= 1'b0;
            o_valid_reg       <= 1'b0;
        end
        else
        begin
            remaining_reg     <= remaining_next;
            running_reg       <= running_next;
            second_phase_reg  <= second_phase_next;
            refresh_phase_reg <= refresh_phase_next;
            position_reg      <= position_next;
            if (cmd.ready)
                p_valid_reg <= cmd.valid;
            if (q_ready)
                q_valid_reg <= q_valid_next;
            if (r_ready)
                r_valid_reg <= q_valid_reg;
            if (o_ready)
                o_valid_reg <= r_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            p_func_reg  <= cmd.func;
            p_start_reg <= cmd.start_seconds;
        end
        if (q_ready)
        begin
            q_pos_reg       <= position_reg;
            q_remaining_reg <= remaining_next;
            q_running_reg   <= running_next;
            q_dot_reg       <= (position_reg == colon_position_reg);
        end
        if (r_ready)
        begin
            r_pos_reg       <= q_pos_reg;
            r_remaining_reg <= q_remaining_reg;
            r_running_reg   <= q_running_reg;
            r_dot_reg       <= q_dot_reg;
            r_minutes_reg   <= r_minutes_next;
        end
        if (o_ready)
        begin
            o_pos_reg       <= r_pos_reg;
            o_seg_reg       <= o_seg_next;
            o_remaining_reg <= r_remaining_reg;
            o_running_reg   <= r_running_reg;
        end
    end

    assign disp.valid        = o_valid_reg;
    assign disp.digit_select = o_pos_reg;
    assign disp.segment_byte = o_seg_reg;
    assign disp.seconds_left = o_remaining_reg;
    assign disp.counting     = o_running_reg;

endmodule

### design/cdtssm_checker.sv
// port-level checks for the countdown timer display block and their binding
`timescale 1ns / 1ps

module cdtssm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           disp_valid,
    input logic                           disp_ready,
    input logic [cdtssm_pkg::POS_W-1:0]   disp_digit_select,
    input logic [cdtssm_pkg::SEG_W-1:0]   disp_segment_byte,
    input logic [cdtssm_pkg::COUNT_W-1:0] disp_seconds_left,
    input logic                           disp_counting
);

    // stalled item holds
    a_disp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && !disp_ready |=> disp_valid
            && $stable(disp_digit_select) && $stable(disp_segment_byte)
            && $stable(disp_seconds_left) && $stable(disp_counting))
        else $error("display item changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid |-> disp_seconds_left <= cdtssm_pkg::MAX_COUNT)
        else $error("seconds_left above clamp");

    // a stopped timer only ever rests at zero
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && !disp_counting |-> disp_seconds_left == '0)
        else $error("stopped with nonzero count");

    // leftmost digit reads zero below ten minutes
    a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_digit_select == '0 && disp_seconds_left < 14'd600
            |-> disp_segment_byte[6:0] == 7'h3F)
        else $error("wrong tens-of-minutes digit");

endmodule

bind countdown_timer_seven_segment_mux_unit cdtssm_checker u_cdtssm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .disp_valid        (disp.valid),
    .disp_ready        (disp.ready),
    .disp_digit_select (disp.digit_select),
    .disp_segment_byte (disp.segment_byte),
    .disp_seconds_left (disp.seconds_left),
    .disp_counting     (disp.counting)
);
